[src/chkv_pkg.sv]
`default_nettype none
package chkv_pkg;
    localparam int BUCKETS_DEF    = 64;
    localparam int NAME_BYTES_DEF = 16;
    localparam int NODES_DEF      = 256;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_UPDATE = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_SEARCH = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_NEW    = 2'd0,
        ST_HIT    = 2'd1,
        ST_MISS   = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    function automatic logic [31:0] oaat_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = h + {24'd0, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [31:0] oaat_final(input logic [31:0] h);
        logic [31:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction
endpackage
`default_nettype wire

[src/chained_hash_key_value_table_unit.sv]
`default_nettype none
// Chained hash key-value table. Key bytes arrive one word per cycle while the
// unit is idle and feed a one-at-a-time hash. On the last byte the
// sequencer first clears nothing further (bucket heads have per-entry valid
// bits; after reset a one-time pass pushes every node index into the free
// list, during which no word is accepted). The operation then reads the
// bucket head in states S_HEAD and S_HEAD2 and walks the bucket chain: per
// visited node it passes S_NODE, S_NODE2 and S_CMP, where one shared byte
// comparator reads the name memory one byte per cycle against the key of
// length L; insert of a new key then pops a free node and copies the key.
// A result waits in an output register; the next word is taken once the
// operation has finished, and an operation that finishes while an earlier
// result is still unread holds until that result is taken.
module chained_hash_key_value_table_unit #(
    parameter int BUCKETS    = chkv_pkg::BUCKETS_DEF,
    parameter int NAME_BYTES = chkv_pkg::NAME_BYTES_DEF,
    parameter int NODES      = chkv_pkg::NODES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_key_byte,
    input  wire logic        i_key_last,
    input  wire logic [31:0] i_salary,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_record_salary,
    output logic [31:0]      o_record_hash,
    output logic [31:0]      o_previous_salary
);
    import chkv_pkg::*;

    localparam int KMAX = NAME_BYTES - 1;
    localparam int KW   = $clog2(KMAX + 1);
    localparam int KIW  = (KMAX > 1) ? $clog2(KMAX) : 1;
    localparam int NW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW   = $clog2(NODES + 1);
    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int AW   = $clog2(NODES * KMAX);

    typedef enum logic [10:0] {
        S_INIT  = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_HEAD  = 11'b00000000100,
        S_HEAD2 = 11'b00000001000,
        S_NODE  = 11'b00000010000,
        S_NODE2 = 11'b00000100000,
        S_CMP   = 11'b00001000000,
        S_OP    = 11'b00010000000,
        S_POP   = 11'b00100000000,
        S_COPY  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_acc;
    logic [7:0]  r_kbuf [KMAX];
    logic [KW-1:0] r_klen;
    logic        r_over;
    logic [1:0]  r_func;
    logic [31:0] r_sal, r_hash;
    logic [BW-1:0] r_bucket;

    logic [LW-1:0] r_head [BUCKETS];
    logic [BUCKETS-1:0] r_head_v;

    logic [LW-1:0] m_next [NODES];
    logic [7:0]    m_name [NODES * KMAX];
    logic [KW-1:0] m_len  [NODES];
    logic [31:0]   m_salv [NODES];
    logic [NW-1:0] m_free [NODES];
    logic [LW-1:0] r_fcnt;

    logic [LW-1:0] r_cur, r_prev;
    logic [LW-1:0] r_steps;
    logic [KW-1:0] r_bi;
    logic [LW-1:0] d_next;
    logic [KW-1:0] d_len;
    logic [31:0]   d_sal;
    logic [7:0]    d_byte;
    logic [NW-1:0] d_free;
    logic [LW-1:0] d_head;
    logic          r_found;

    logic          r_ov;
    logic [1:0]    r_ost;
    logic [31:0]   r_orec, r_ohash, r_oprev;

    logic          acc_go;
    logic [31:0]   acc_new, hash_f;
    logic [NW-1:0] cur_i;
    logic [AW-1:0] name_addr;
    logic [KW-1:0] rd_bi;
    logic [AW-1:0] rd_addr;

    assign o_ready = (r_state == S_IDLE);
    assign acc_go  = i_valid && o_ready;
    assign acc_new = (i_key_byte != 8'd0) ? oaat_step(r_acc, i_key_byte) : r_acc;
    assign hash_f  = oaat_final(acc_new);
    assign cur_i   = r_cur[NW-1:0];
    assign name_addr = AW'(cur_i * KMAX) + AW'(r_bi);
    assign rd_bi   = (r_state == S_CMP) ? KW'(r_bi + 1'b1) : r_bi;
    assign rd_addr = AW'(cur_i * KMAX) + AW'(rd_bi);

    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_record_salary = r_orec;
    assign o_record_hash = r_ohash;
    assign o_previous_salary = r_oprev;

    always_ff @(posedge i_clk) begin
        d_next <= m_next[cur_i];
        d_len  <= m_len[cur_i];
        d_sal  <= m_salv[cur_i];
        d_byte <= m_name[rd_addr];
        d_free <= m_free[NW'(r_fcnt - 1'b1)];
        d_head <= r_head_v[r_bucket] ? r_head[r_bucket] : LW'(NODES);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:  if (r_fcnt == LW'(NODES - 1)) n_state = S_IDLE;
            S_IDLE:  if (acc_go && i_key_last) n_state = S_HEAD;
            S_HEAD:  n_state = S_HEAD2;
            S_HEAD2: n_state = S_NODE;
            S_NODE:  n_state = (r_cur == LW'(NODES) || r_steps == LW'(NODES)) ? S_OP : S_NODE2;
            S_NODE2: n_state = S_CMP;
            S_CMP:   n_state = S_CMP;
            S_OP:    n_state = r_ov ? S_OP : S_OUT;
            S_POP:   n_state = S_COPY;
            S_COPY:  n_state = S_COPY;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_CMP) begin
            if (d_len != r_klen) n_state = S_NODE;
            else if (r_bi != r_klen && d_byte != r_kbuf[KIW'(r_bi)]) n_state = S_NODE;
            else if (r_bi == r_klen) n_state = S_OP;
        end
        if (r_state == S_OP && !r_ov && !r_found && r_func == FUNC_INSERT && !r_over &&
            r_fcnt != '0)
            n_state = S_POP;
        if (r_state == S_COPY && r_bi == r_klen) n_state = S_OUT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_acc    <= '0;
            r_klen   <= '0;
            r_over   <= 1'b0;
            r_head_v <= '0;
            r_fcnt   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    m_free[NW'(r_fcnt)] <= NW'(r_fcnt);
                    r_fcnt <= r_fcnt + 1'b1;
                    if (r_fcnt == LW'(NODES - 1)) r_fcnt <= LW'(NODES);
                end
                S_IDLE: if (acc_go) begin
                    r_acc <= acc_new;
                    if (i_key_byte != 8'd0) begin
                        if (r_klen < KW'(KMAX)) begin
                            r_kbuf[KIW'(r_klen)] <= i_key_byte;
                            r_klen <= r_klen + 1'b1;
                        end else r_over <= 1'b1;
                    end
                    if (i_key_last) begin
                        r_func   <= i_func;
                        r_sal    <= i_salary;
                        r_hash   <= hash_f;
                        r_bucket <= BW'(hash_f % BUCKETS);
                    end
                end
                S_HEAD: begin
                    r_prev  <= LW'(NODES);
                    r_steps <= '0;
                    r_found <= 1'b0;
                end
                S_HEAD2: r_cur <= r_over ? LW'(NODES) : d_head;
                S_NODE: r_bi <= '0;
                S_NODE2: ;
                S_CMP: begin
                    r_bi <= r_bi + 1'b1;
                    if (d_len != r_klen ||
                        (r_bi != r_klen && d_byte != r_kbuf[KIW'(r_bi)])) begin
                        r_prev  <= r_cur;
                        r_cur   <= d_next;
                        r_steps <= r_steps + 1'b1;
                    end else if (r_bi == r_klen) r_found <= 1'b1;
                end
                S_OP: if (!r_ov) begin
                    r_ov    <= 1'b1;
                    r_ohash <= r_hash;
                    r_ost   <= ST_MISS;
                    r_orec  <= '0;
                    r_oprev <= '0;
                    r_bi    <= '0;
                    if (r_found) begin
                        r_ost  <= ST_HIT;
                        r_orec <= d_sal;
                        unique case (t_func'(r_func))
                            FUNC_INSERT: begin
                                r_oprev <= d_sal;
                                m_salv[cur_i] <= r_sal;
                            end
                            FUNC_UPDATE: begin
                                r_oprev <= d_sal;
                                r_orec  <= r_sal;
                                m_salv[cur_i] <= r_sal;
                            end
                            FUNC_DELETE: begin
                                if (r_prev != LW'(NODES)) m_next[NW'(r_prev)] <= d_next;
                                else r_head[r_bucket] <= d_next;
                                if (r_fcnt != LW'(NODES)) begin
                                    m_free[NW'(r_fcnt)] <= cur_i;
                                    r_fcnt <= r_fcnt + 1'b1;
                                end
                            end
                            FUNC_SEARCH: ;
                        endcase
                    end else if (r_func == FUNC_INSERT) begin
                        if (r_over || r_fcnt == '0) r_ost <= ST_REJECT;
                        else begin
                            r_ov   <= 1'b0;
                            r_ost  <= ST_NEW;
                            r_orec <= r_sal;
                        end
                    end
                end
                S_POP: begin
                    r_cur  <= LW'(d_free);
                    r_fcnt <= r_fcnt - 1'b1;
                    r_bi   <= '0;
                end
                S_COPY: begin
                    if (r_bi == '0) begin
                        m_salv[cur_i] <= r_sal;
                        m_len[cur_i]  <= r_klen;
                        m_next[cur_i] <= d_head;
                        r_head[r_bucket] <= r_cur;
                        r_head_v[r_bucket] <= 1'b1;
                    end
                    if (r_bi != r_klen) m_name[name_addr] <= r_kbuf[KIW'(r_bi)];
                    r_bi <= r_bi + 1'b1;
                    if (r_bi == r_klen) r_ov <= 1'b1;
                end
                S_OUT: begin
                    r_acc  <= '0;
                    r_klen <= '0;
                    r_over <= 1'b0;
                end
                default: ;
            endcase
            if (r_state == S_OP && !r_ov && r_found && r_func == FUNC_DELETE &&
                r_prev == LW'(NODES))
                r_head_v[r_bucket] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

[src/chkv_checker.sv]
`default_nettype none
module chkv_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_record_salary,
    input wire logic [31:0] o_previous_salary
);
    import chkv_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_record_salary))
        else $error("result word dropped");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_MISS || o_status == ST_REJECT) |-> o_record_salary == 32'd0)
        else $error("miss with salary");
    a_new_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NEW |-> o_previous_salary == 32'd0)
        else $error("new insert with previous salary");
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("ready during init");
endmodule
bind chained_hash_key_value_table_unit chkv_checker u_chk (.*);
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
    import chkv_pkg::*;

    localparam int NB    = 64;
    localparam int KMAX  = 15;
    localparam int NN    = 256;
    localparam int LIMIT = 200000;

    typedef struct {
        t_status     status;
        logic [31:0] rec_salary;
        logic [31:0] rec_hash;
        logic [31:0] prev_salary;
    } t_lookup;

    class table_scoreboard;
        logic [31:0] acc;
        logic [7:0]  kbuf [KMAX];
        int          klen;
        bit          kover;
        int          heads [NB];
        int          nxt [NN];
        logic [7:0]  names [NN][KMAX];
        int          nlen [NN];
        logic [31:0] sal [NN];
        int          pool [NN];
        int          pool_cnt;
        t_lookup     pending [$];
        int          errors;

        function void clear_table();
            acc = 0;
            klen = 0;
            kover = 0;
            foreach (heads[i]) heads[i] = NN;
            foreach (pool[i]) pool[i] = i;
            pool_cnt = NN;
            pending.delete();
            errors = 0;
        endfunction

        function bit same_name(int n);
            if (nlen[n] != klen) return 0;
            for (int i = 0; i < klen; i++)
                if (names[n][i] != kbuf[i]) return 0;
            return 1;
        endfunction

        function void note_word(t_func f, logic [7:0] b, bit last, logic [31:0] s);
            logic [31:0] h;
            int bk, cur, prv, node;
            bit hit;
            t_lookup r;
            if (b != 0) begin
                acc = acc + b;
                acc = acc + (acc << 10);
                acc = acc ^ (acc >> 6);
                if (klen < KMAX) begin
                    kbuf[klen] = b;
                    klen++;
                end else begin
                    kover = 1;
                end
            end
            if (!last) return;
            h = acc + (acc << 3);
            h = h ^ (h >> 11);
            h = h + (h << 15);
            bk = h % NB;
            prv = NN;
            cur = NN;
            hit = 0;
            if (!kover) begin
                cur = heads[bk];
                while (cur < NN) begin
                    if (same_name(cur)) begin
                        hit = 1;
                        break;
                    end
                    prv = cur;
                    cur = nxt[cur];
                end
            end
            r.status = ST_MISS;
            r.rec_salary = 0;
            r.rec_hash = h;
            r.prev_salary = 0;
            if (hit) begin
                r.status = ST_HIT;
                case (f)
                    FUNC_INSERT: begin
                        r.rec_salary = sal[cur];
                        r.prev_salary = sal[cur];
                        sal[cur] = s;
                    end
                    FUNC_UPDATE: begin
                        r.prev_salary = sal[cur];
                        sal[cur] = s;
                        r.rec_salary = s;
                    end
                    FUNC_DELETE: begin
                        r.rec_salary = sal[cur];
                        if (prv < NN) nxt[prv] = nxt[cur];
                        else heads[bk] = nxt[cur];
                        if (pool_cnt < NN) begin
                            pool[pool_cnt] = cur;
                            pool_cnt++;
                        end
                    end
                    default: r.rec_salary = sal[cur];
                endcase
            end else if (f == FUNC_INSERT) begin
                if (kover || pool_cnt == 0) begin
                    r.status = ST_REJECT;
                end else begin
                    pool_cnt--;
                    node = pool[pool_cnt];
                    sal[node] = s;
                    nlen[node] = klen;
                    for (int i = 0; i < klen; i++) names[node][i] = kbuf[i];
                    nxt[node] = heads[bk];
                    heads[bk] = node;
                    r.status = ST_NEW;
                    r.rec_salary = s;
                end
            end
            pending.push_back(r);
            acc = 0;
            klen = 0;
            kover = 0;
        endfunction

        function void check_word(logic [1:0] st, logic [31:0] rs, logic [31:0] rh,
                                 logic [31:0] ps);
            t_lookup e;
            if (pending.size() == 0) begin
                $display("%0t unexpected word: status %0d", $time, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $display("%0t status exp %0d got %0d", $time, e.status, st);
                errors++;
            end
            if (rs !== e.rec_salary) begin
                $display("%0t record_salary exp %h got %h", $time, e.rec_salary, rs);
                errors++;
            end
            if (rh !== e.rec_hash) begin
                $display("%0t record_hash exp %h got %h", $time, e.rec_hash, rh);
                errors++;
            end
            if (ps !== e.prev_salary) begin
                $display("%0t previous_salary exp %h got %h", $time, e.prev_salary, ps);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_func;
    logic [7:0]  i_key_byte;
    logic        i_key_last;
    logic [31:0] i_salary;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [31:0] o_record_salary;
    logic [31:0] o_record_hash;
    logic [31:0] o_previous_salary;

    chained_hash_key_value_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_key_byte(i_key_byte),
        .i_key_last(i_key_last), .i_salary(i_salary),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_record_salary(o_record_salary),
        .o_record_hash(o_record_hash), .o_previous_salary(o_previous_salary)
    );

    table_scoreboard sb;
    bit  calm;
    int  idle_cycles;
    logic [7:0] keys [32][20];
    int  key_len [32];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_word(t_func'(i_func), i_key_byte, i_key_last, i_salary);
        if (i_rst_n && o_valid && i_ready)
            sb.check_word(o_status, o_record_salary, o_record_hash, o_previous_salary);
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_ready <= 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_ready <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            i_ready <= 1;
        end else begin
            i_ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_word(t_func f, logic [7:0] b, bit last, logic [31:0] s);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_func <= f;
        i_key_byte <= b;
        i_key_last <= last;
        i_salary <= s;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_key(t_func f, int k, logic [31:0] s);
        for (int i = 0; i < key_len[k]; i++)
            send_word(f, keys[k][i], i == key_len[k] - 1, s);
        if (key_len[k] == 0) send_word(f, 8'd0, 1, s);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int k, n;
        sb = new();
        sb.clear_table();
        calm = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_func = FUNC_INSERT;
        i_key_byte = 0;
        i_key_last = 0;
        i_salary = 0;
        i_ready = 1;
        for (int i = 0; i < 32; i++) begin
            key_len[i] = (i < 4) ? i + 1 : $urandom_range(1, (i < 28) ? 6 : 18);
            for (int j = 0; j < 20; j++) keys[i][j] = 8'($urandom_range(1, 255));
        end
        keys[0][0] = 8'd255;
        keys[1][0] = 8'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        send_key(FUNC_SEARCH, 0, 0);
        send_key(FUNC_INSERT, 0, 32'hFFFF_FFFF);
        send_key(FUNC_INSERT, 0, 32'h0);
        send_key(FUNC_UPDATE, 0, 32'h1234_5678);
        send_key(FUNC_SEARCH, 0, 0);
        send_key(FUNC_DELETE, 0, 0);
        send_key(FUNC_DELETE, 0, 0);
        send_key(FUNC_UPDATE, 1, 5);
        send_word(FUNC_INSERT, 8'd0, 1, 32'hAAAA_5555);
        send_word(FUNC_SEARCH, 8'd0, 1, 0);
        send_word(FUNC_INSERT, 8'd7, 0, 0);
        send_word(FUNC_INSERT, 8'd0, 0, 0);
        send_word(FUNC_INSERT, 8'd0, 1, 32'h5555_AAAA);
        for (int i = 0; i < 17; i++) send_word(FUNC_INSERT, 8'hA5, i == 16, 9);
        send_key(FUNC_INSERT, 3, 77);
        drain();

        n = 0;
        while (n < 390) begin
            k = $urandom_range(0, 31);
            if ($urandom_range(0, 19) == 0) begin
                send_word(t_func'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), $urandom);
                n++;
            end else begin
                send_key(t_func'($urandom_range(0, 3)), k, $urandom);
                n += key_len[k];
            end
            if (n > 200 && n < 220) drain();
        end

        calm = 1;
        for (int i = 0; i < 260; i++) begin
            send_word(FUNC_INSERT, 8'(i % 255 + 1), 0, 0);
            send_word(FUNC_INSERT, 8'(i / 255 + 8'h40), 1, 32'(i));
        end
        send_key(FUNC_INSERT, 2, 99);
        send_key(FUNC_SEARCH, 2, 0);

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

[chained_hash_key_value_table_unit.f]
src/chkv_pkg.sv
src/chained_hash_key_value_table_unit.sv
src/chkv_checker.sv
bench/tb_top.sv
